### rtl/core/hdi_pkg.sv
package hdi_pkg;

  localparam int ISLAND_WORDS = 18;
  localparam int LAST_WORD    = ISLAND_WORDS - 1;
  localparam int WORD_NUM_W   = 5;
  localparam int HDR_BYTES    = 4;
  localparam int SP_COUNT     = 4;
  localparam int SP_ROWS      = 8;
  localparam int ROW_AW       = 3;
  localparam int PARITY_ROW   = SP_ROWS - 1;
  localparam int STORE_BYTES  = HDR_BYTES + SP_COUNT * SP_ROWS;
  localparam int LANE_W       = 20;

  localparam logic [LANE_W-1:0] GUARD_WORD = 20'h4CD33;
  localparam logic [31:0]       SWAP_MASK7  = 32'h00aa00aa;
  localparam logic [31:0]       SWAP_MASK14 = 32'h0000cccc;
  localparam logic [1:0]        GB_PREFIX   = 2'b11;
  localparam logic [7:0]        BCH_POLY    = 8'h83;

  localparam int          CFG_AW          = 1;
  localparam logic [0:0]  CFG_ADDR_PARITY = 1'b0;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARITY,
    ST_PWRITE,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic                  ld_wr;
    logic                  emit_start;
    logic                  rd_en;
    logic [ROW_AW-1:0]     rd_addr;
    logic                  acc;
    logic                  acc_hdr;
    logic [1:0]            acc_sel;
    logic                  par_wr;
    logic                  out_load;
    logic [WORD_NUM_W-1:0] word_num;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } sts_t;

  function automatic logic [9:0] terc4(input logic [3:0] n);
    logic [9:0] c;
    case (n)
      4'h0: c = 10'h29C;
      4'h1: c = 10'h263;
      4'h2: c = 10'h2E4;
      4'h3: c = 10'h2E2;
      4'h4: c = 10'h171;
      4'h5: c = 10'h11E;
      4'h6: c = 10'h18E;
      4'h7: c = 10'h13C;
      4'h8: c = 10'h2CC;
      4'h9: c = 10'h139;
      4'hA: c = 10'h19C;
      4'hB: c = 10'h2C6;
      4'hC: c = 10'h28E;
      4'hD: c = 10'h271;
      4'hE: c = 10'h163;
      4'hF: c = 10'h2C3;
      default: c = 10'h29C;
    endcase
    return c;
  endfunction

  function automatic logic [LANE_W-1:0] pair_sym(input logic [3:0] a, input logic [3:0] b);
    return {terc4(b), terc4(a)};
  endfunction

  // one byte of the reflected bch crc
  function automatic logic [7:0] bch_step(input logic [7:0] x);
    logic [7:0] c;
    c = x;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ BCH_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // 4x8 bit transpose of one subpacket row
  function automatic logic [31:0] transpose(input logic [31:0] v_in);
    logic [31:0] v;
    logic [31:0] t;
    v = v_in;
    t = (v ^ (v >> 7)) & SWAP_MASK7;
    v = v ^ t ^ (t << 7);
    t = (v ^ (v >> 14)) & SWAP_MASK14;
    v = v ^ t ^ (t << 14);
    return v;
  endfunction

endpackage

### rtl/core/hdi_in_if.sv
interface hdi_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [5:0] byte_index;
  logic [7:0] byte_value;
  logic       vsync;
  logic       hsync;

  modport source (output valid, action, byte_index, byte_value, vsync, hsync, input ready);
  modport sink (input valid, action, byte_index, byte_value, vsync, hsync, output ready);
endinterface

### rtl/core/hdi_out_if.sv
interface hdi_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] lane0_word;
  logic [19:0] lane1_word;
  logic [19:0] lane2_word;
  logic [4:0]  word_number;
  logic        last;

  modport source (output valid, lane0_word, lane1_word, lane2_word, word_number, last,
                  input ready);
  modport sink (input valid, lane0_word, lane1_word, lane2_word, word_number, last,
                output ready);
endinterface

### rtl/core/hdi_ram.sv
module hdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/hdi_ctrl.sv
module hdi_ctrl
  import hdi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_action,
  input  logic parity_mode,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t                state_r, state_nxt;
  logic [WORD_NUM_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_EMIT) begin
          state_nxt = parity_mode ? ST_PARITY : ST_STREAM;
          cnt_nxt   = '0;
        end
      end
      ST_PARITY: begin
        if (cnt_r == WORD_NUM_W'(PARITY_ROW)) begin
          state_nxt = ST_PWRITE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_PWRITE: begin
        state_nxt = ST_STREAM;
        cnt_nxt   = '0;
      end
      ST_STREAM: begin
        if (sts.slot_free) begin
          if (cnt_r == WORD_NUM_W'(LAST_WORD)) begin
            state_nxt = ST_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.word_num = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.ld_wr      = in_valid && in_action == ACT_LOAD;
        cmd.emit_start = in_valid && in_action == ACT_EMIT;
      end
      ST_PARITY: begin
        cmd.rd_en   = cnt_r < WORD_NUM_W'(PARITY_ROW);
        cmd.rd_addr = cnt_r[ROW_AW-1:0];
        cmd.acc     = cnt_r != '0;
        cmd.acc_hdr = cnt_r != '0 && cnt_r < WORD_NUM_W'(HDR_BYTES);
        cmd.acc_sel = cnt_r[1:0] - 2'd1;
      end
      ST_PWRITE: begin
        cmd.par_wr = 1'b1;
      end
      ST_STREAM: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          // prefetch the subpacket row for the next word pair
          cmd.rd_en    = !cnt_r[0] && cnt_r < WORD_NUM_W'(2 * SP_ROWS);
          cmd.rd_addr  = cnt_r[ROW_AW:1];
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_load_only_streaming: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> state_r == ST_STREAM && sts.slot_free)
    else $error("word loaded outside streaming");

  a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STREAM |-> cnt_r <= WORD_NUM_W'(LAST_WORD))
    else $error("word counter out of range");

  a_pwrite_to_stream: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PWRITE |=> state_r == ST_STREAM && cnt_r == '0)
    else $error("parity write not followed by streaming");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM && sts.slot_free && cnt_r == WORD_NUM_W'(LAST_WORD))
      |=> state_r == ST_IDLE)
    else $error("island did not end after last word");

endmodule

### rtl/core/hdi_dp.sv
module hdi_dp
  import hdi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [5:0]        in_byte_index,
  input  logic [7:0]        in_byte_value,
  input  logic              in_vsync,
  input  logic              in_hsync,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LANE_W-1:0] out_lane0_word,
  output logic [LANE_W-1:0] out_lane1_word,
  output logic [LANE_W-1:0] out_lane2_word,
  output logic [4:0]        out_word_number,
  output logic              out_last
);

  logic [HDR_BYTES-1:0][7:0]             hdr_r;
  logic [1:0]                            hv_r;
  logic [SP_COUNT-1:0][SP_ROWS-1:0]      vld_r;
  logic [SP_COUNT-1:0]                   rd_vld_r;
  logic [SP_COUNT-1:0][7:0]              crc_r;
  logic [7:0]                            hcrc_r;
  logic                                  out_valid_r;
  logic [LANE_W-1:0]                     lane0_r, lane1_r, lane2_r;
  logic [WORD_NUM_W-1:0]                 word_r;
  logic                                  last_r;

  logic [5:0]                            ld_off;
  logic                                  ld_hdr, ld_sp;
  logic [1:0]                            ld_sel;
  logic [ROW_AW-1:0]                     ld_row;
  logic [SP_COUNT-1:0]                   ram_we;
  logic [ROW_AW-1:0]                     ram_waddr;
  logic [SP_COUNT-1:0][7:0]              ram_wdata;
  logic [SP_COUNT-1:0][7:0]              ram_rdata;
  logic [SP_COUNT-1:0][7:0]              sp_byte;
  logic [31:0]                           row_t;
  logic [3:0]                            idx;
  logic                                  guard;
  logic [7:0]                            hb;
  logic                                  bit_a, bit_b;
  logic [LANE_W-1:0]                     lane0_nxt, lane1_nxt, lane2_nxt;

  assign ld_off = in_byte_index - 6'(HDR_BYTES);
  assign ld_hdr = in_byte_index < 6'(HDR_BYTES);
  assign ld_sp  = !ld_hdr && in_byte_index < 6'(STORE_BYTES);
  assign ld_sel = ld_off[4:3];
  assign ld_row = ld_off[ROW_AW-1:0];

  assign ram_waddr = cmd.par_wr ? ROW_AW'(PARITY_ROW) : ld_row;

  for (genvar k = 0; k < SP_COUNT; k++) begin : g_sp
    assign ram_we[k]    = cmd.par_wr || (cmd.ld_wr && ld_sp && ld_sel == 2'(k));
    assign ram_wdata[k] = cmd.par_wr ? crc_r[k] : in_byte_value;
    assign sp_byte[k]   = rd_vld_r[k] ? ram_rdata[k] : 8'h00;

    hdi_ram #(
      .WIDTH (8),
      .DEPTH (SP_ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[k]),
      .waddr (ram_waddr),
      .wdata (ram_wdata[k]),
      .re    (cmd.rd_en),
      .raddr (cmd.rd_addr),
      .rdata (ram_rdata[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r       <= '0;
      hv_r        <= '0;
      vld_r       <= '0;
      rd_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_wr && ld_hdr) begin
        hdr_r[in_byte_index[1:0]] <= in_byte_value;
      end
      if (cmd.par_wr) begin
        hdr_r[HDR_BYTES-1] <= hcrc_r;
      end
      if (cmd.emit_start) begin
        hv_r <= {in_vsync, in_hsync};
      end
      for (int k = 0; k < SP_COUNT; k++) begin
        if (ram_we[k]) begin
          vld_r[k][ram_waddr] <= 1'b1;
        end
        if (cmd.rd_en) begin
          rd_vld_r[k] <= vld_r[k][cmd.rd_addr];
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // parity accumulators
  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      crc_r  <= '0;
      hcrc_r <= '0;
    end else if (cmd.acc) begin
      for (int k = 0; k < SP_COUNT; k++) begin
        crc_r[k] <= bch_step(crc_r[k] ^ sp_byte[k]);
      end
      if (cmd.acc_hdr) begin
        hcrc_r <= bch_step(hcrc_r ^ hdr_r[cmd.acc_sel]);
      end
    end
  end

  // word assembly
  always_comb begin
    idx   = 4'(cmd.word_num - 5'd1);
    guard = cmd.word_num == '0 || cmd.word_num == WORD_NUM_W'(LAST_WORD);
    hb    = hdr_r[idx[3:2]];
    bit_a = hb[{idx[1:0], 1'b0}];
    bit_b = hb[{idx[1:0], 1'b1}];
    row_t = transpose({sp_byte[3], sp_byte[2], sp_byte[1], sp_byte[0]});
    if (guard) begin
      lane0_nxt = pair_sym({GB_PREFIX, hv_r}, {GB_PREFIX, hv_r});
      lane1_nxt = GUARD_WORD;
      lane2_nxt = GUARD_WORD;
    end else begin
      lane0_nxt = pair_sym({idx != '0, bit_a, hv_r}, {1'b1, bit_b, hv_r});
      if (!idx[0]) begin
        lane1_nxt = pair_sym(row_t[3:0], row_t[19:16]);
        lane2_nxt = pair_sym(row_t[11:8], row_t[27:24]);
      end else begin
        lane1_nxt = pair_sym(row_t[7:4], row_t[23:20]);
        lane2_nxt = pair_sym(row_t[15:12], row_t[31:28]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      lane0_r <= lane0_nxt;
      lane1_r <= lane1_nxt;
      lane2_r <= lane2_nxt;
      word_r  <= cmd.word_num;
      last_r  <= cmd.word_num == WORD_NUM_W'(LAST_WORD);
    end
  end

  assign sts.slot_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_lane0_word  = lane0_r;
  assign out_lane1_word  = lane1_r;
  assign out_lane2_word  = lane2_r;
  assign out_word_number = word_r;
  assign out_last        = last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("pending transaction overwritten");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.par_wr && cmd.ld_wr))
    else $error("parity write and byte load in one cycle");

  a_parity_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.par_wr |=> vld_r[0][PARITY_ROW] && vld_r[SP_COUNT-1][PARITY_ROW])
    else $error("parity row not marked written");

endmodule

### rtl/core/hdmi_data_island_encoder.sv
// channel | ports       | direction | contents
// input   | in_ch.*     | sink      | action, byte_index, byte_value, vsync, hsync
// result  | out_ch.*    | source    | lane0/1/2_word, word_number, last
// config  | cfg_p*      | apb slave | parity_mode at address 0
//
// an emit transaction streams 18 words at one per cycle while out_ch is not stalled; with
//   parity_mode set a parity pass over the subpacket rows comes first, one row per cycle
//   through the single read port of the subpacket rams
// the input is taken only while no island is in progress
// stalls on out_ch hold the word register and pause the word counter
// synchronous reset clears the packet store to a null packet and sets parity_mode
module hdmi_data_island_encoder
  import hdi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  hdi_in_if.sink            in_ch,
  hdi_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic parity_mode_r;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_mode_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_ADDR_PARITY) begin
      parity_mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_PARITY) ? {31'b0, parity_mode_r} : 32'b0;

  assign in_ch.ready = in_ready;

  hdi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_action   (in_ch.action),
    .parity_mode (parity_mode_r),
    .sts         (sts),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  hdi_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_byte_index   (in_ch.byte_index),
    .in_byte_value   (in_ch.byte_value),
    .in_vsync        (in_ch.vsync),
    .in_hsync        (in_ch.hsync),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_lane0_word  (out_ch.lane0_word),
    .out_lane1_word  (out_ch.lane1_word),
    .out_lane2_word  (out_ch.lane2_word),
    .out_word_number (out_ch.word_number),
    .out_last        (out_ch.last)
  );

endmodule
